@@ sv/length_field_frame_receiver_macros.svh @@
// ---------------------------------------------------------------------------
// length field frame receiver: assertion macros
// ---------------------------------------------------------------------------
`ifndef LENGTH_FIELD_FRAME_RECEIVER_MACROS_SVH
`define LENGTH_FIELD_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, disabled during reset
`define LFFR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LFFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/lffr_pkg.sv @@
// ---------------------------------------------------------------------------
// lffr_pkg
// Shared types and constants of the length field frame receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package lffr_pkg;

   // fixed widths and frame format
   localparam int COUNT_W = 9;
   localparam logic [COUNT_W-1:0] LENGTH_POSITION = 9'd8;
   localparam logic [COUNT_W-1:0] LENGTH_OFFSET = 9'd11;
   localparam int BUFFER_BYTES_DEF = 128;

   // configuration register indexes and reset values
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_BYTE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_BYTE = 1'b1;
   localparam logic [7:0] START_BYTE_RESET = 8'h55;
   localparam logic [7:0] END_BYTE_RESET = 8'hAA;

   // request operations
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_IGNORED  = 2'd0,
      STATUS_STORED   = 2'd1,
      STATUS_COMPLETE = 2'd2,
      STATUS_DROPPED  = 2'd3
   } status_type;

   // receiver phase, one-hot
   typedef enum logic [3:0] {
      PHASE_HUNT   = 4'b0001,
      PHASE_HEADER = 4'b0010,
      PHASE_DATA   = 4'b0100,
      PHASE_HELD   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] byte_in;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] byte_out;
      logic [7:0] position;
      logic       frame_done;
   } rsp_type;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] end_byte;
   } cfg_type;

endpackage

`default_nettype wire

@@ sv/lffr_frame_fsm.sv @@
// ---------------------------------------------------------------------------
// lffr_frame_fsm
// Frame tracking state and per-byte result, one accepted request per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
`include "length_field_frame_receiver_macros.svh"

module lffr_frame_fsm #(
   parameter int BUFFER_BYTES = lffr_pkg::BUFFER_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire lffr_pkg::req_type req,
   input  wire lffr_pkg::cfg_type cfg,
   output lffr_pkg::rsp_type      rsp
);

   localparam logic [lffr_pkg::COUNT_W-1:0] BUF_LIMIT = lffr_pkg::COUNT_W'(BUFFER_BYTES);

   lffr_pkg::phase_type             phase_ff, phase_in;
   logic [lffr_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [lffr_pkg::COUNT_W-1:0]    length_ff, length_in;
   logic [lffr_pkg::COUNT_W-1:0]    count_inc;
   lffr_pkg::status_type            status;

   assign count_inc = count_ff + lffr_pkg::COUNT_W'(1);

   // next state and result for the request at the port
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      length_in = length_ff;
      status = lffr_pkg::STATUS_IGNORED;
      rsp = '0;
      if (req.operation == lffr_pkg::OP_RELEASE) begin
         if (phase_ff == lffr_pkg::PHASE_HELD) begin
            phase_in = lffr_pkg::PHASE_HUNT;
         end
      end else begin
         case (phase_ff)
            lffr_pkg::PHASE_HUNT: begin
               if (req.byte_in == cfg.start_byte) begin
                  phase_in = lffr_pkg::PHASE_HEADER;
                  count_in = lffr_pkg::COUNT_W'(1);
                  status = lffr_pkg::STATUS_STORED;
               end
            end
            lffr_pkg::PHASE_HEADER: begin
               count_in = count_inc;
               status = lffr_pkg::STATUS_STORED;
               if (count_inc == lffr_pkg::LENGTH_POSITION) begin
                  length_in = lffr_pkg::COUNT_W'(req.byte_in) + lffr_pkg::LENGTH_OFFSET;
                  phase_in = lffr_pkg::PHASE_DATA;
               end
               if (count_inc > BUF_LIMIT) begin
                  phase_in = lffr_pkg::PHASE_HUNT;
                  status = lffr_pkg::STATUS_DROPPED;
               end
            end
            lffr_pkg::PHASE_DATA: begin
               count_in = count_inc;
               status = lffr_pkg::STATUS_STORED;
               if (count_inc > BUF_LIMIT) begin
                  phase_in = lffr_pkg::PHASE_HUNT;
                  status = lffr_pkg::STATUS_DROPPED;
               end
               // end check wins over overflow
               if (count_inc >= length_ff) begin
                  if (req.byte_in == cfg.end_byte) begin
                     phase_in = lffr_pkg::PHASE_HELD;
                     status = lffr_pkg::STATUS_COMPLETE;
                  end else begin
                     phase_in = lffr_pkg::PHASE_HUNT;
                     status = lffr_pkg::STATUS_DROPPED;
                  end
               end
            end
            lffr_pkg::PHASE_HELD: begin
               phase_in = lffr_pkg::PHASE_HELD;
            end
            default: begin
               phase_in = lffr_pkg::PHASE_HUNT;
            end
         endcase
      end
      rsp.status = status;
      if (status != lffr_pkg::STATUS_IGNORED) begin
         rsp.byte_out = req.byte_in;
         // start byte reports position zero
         rsp.position = (phase_ff == lffr_pkg::PHASE_HUNT) ? 8'd0 : count_ff[7:0];
      end
      rsp.frame_done = (status == lffr_pkg::STATUS_COMPLETE);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lffr_pkg::PHASE_HUNT;
         count_ff <= '0;
         length_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         length_ff <= length_in;
      end
   end

   // checks
   `LFFR_ASSERT_NEXT(a_complete_holds, clock, reset,
      accept && rsp.status == lffr_pkg::STATUS_COMPLETE, phase_ff == lffr_pkg::PHASE_HELD,
      "completed frame did not enter held phase")
   `LFFR_ASSERT_NEXT(a_drop_hunts, clock, reset,
      accept && rsp.status == lffr_pkg::STATUS_DROPPED, phase_ff == lffr_pkg::PHASE_HUNT,
      "dropped frame did not return to hunt")
   `LFFR_ASSERT_NOW(a_data_bounds, clock, reset,
      phase_ff == lffr_pkg::PHASE_DATA, count_ff < length_ff && count_ff <= BUF_LIMIT,
      "data phase count out of range")
   `LFFR_ASSERT_NOW(a_held_ignores, clock, reset,
      accept && phase_ff == lffr_pkg::PHASE_HELD, rsp.status == lffr_pkg::STATUS_IGNORED,
      "byte taken while held")

endmodule

`default_nettype wire

@@ sv/lffr_out_skid.sv @@
// ---------------------------------------------------------------------------
// lffr_out_skid
// Result register with a skid slot, so stall toward the request side is registered.
// ---------------------------------------------------------------------------
`default_nettype none
`include "length_field_frame_receiver_macros.svh"

module lffr_out_skid (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_stall,
   input  wire lffr_pkg::rsp_type in_data,
   output logic                   out_valid,
   input  wire logic              out_stall,
   output lffr_pkg::rsp_type      out_data
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   lffr_pkg::rsp_type out_data_ff, out_data_in;
   lffr_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              in_take;
   logic              out_free;

   assign in_stall = skid_valid_ff;
   assign in_take = in_valid && !skid_valid_ff;
   assign out_free = !out_valid_ff || !out_stall;
   assign out_valid = out_valid_ff;
   assign out_data = out_data_ff;

   // slot steering
   always_comb begin
      out_valid_in = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in = out_data_ff;
      skid_data_in = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_take;
            out_data_in = in_data;
         end
      end else if (in_take) begin
         skid_valid_in = 1'b1;
         skid_data_in = in_data;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // checks
   `LFFR_ASSERT_NOW(a_skid_behind_out, clock, reset,
      skid_valid_ff, out_valid_ff, "skid slot full with empty output slot")
   `LFFR_ASSERT_NEXT(a_stalled_take_skids, clock, reset,
      in_take && out_valid_ff && out_stall, skid_valid_ff,
      "request taken under stall not kept in skid slot")
   `LFFR_ASSERT_NEXT(a_skid_drains, clock, reset,
      skid_valid_ff && !out_stall, !skid_valid_ff && out_valid_ff,
      "skid slot did not drain into output slot")

endmodule

`default_nettype wire

@@ sv/length_field_frame_receiver.sv @@
// A result is registered in the output slot, or the skid slot under stall.
// Throughput: one request per cycle; req_stall rises only while the skid slot
// holds a result that the output side has not yet taken.
// Reset: phase returns to hunt, counters clear, start/end bytes go to 0x55/0xAA,
// and any buffered results are discarded.
// ---------------------------------------------------------------------------
// length_field_frame_receiver
// Finds length-delimited frames in a byte stream and streams each byte out
// with its position and a frame status.
// ---------------------------------------------------------------------------
`default_nettype none

module length_field_frame_receiver #(
   parameter int BUFFER_BYTES = lffr_pkg::BUFFER_BYTES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire lffr_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output lffr_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [lffr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                       csr_wdata
);

   lffr_pkg::cfg_type cfg_ff;
   lffr_pkg::rsp_type result;
   logic              req_accept;

   assign req_accept = req_valid && !req_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte <= lffr_pkg::START_BYTE_RESET;
         cfg_ff.end_byte <= lffr_pkg::END_BYTE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lffr_pkg::CSR_START_BYTE: cfg_ff.start_byte <= csr_wdata;
            lffr_pkg::CSR_END_BYTE: cfg_ff.end_byte <= csr_wdata;
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   // frame tracking
   lffr_frame_fsm #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_frame_fsm (
      .clock (clock),
      .reset (reset),
      .accept(req_accept),
      .req   (req_data),
      .cfg   (cfg_ff),
      .rsp   (result)
   );

   // result buffering
   lffr_out_skid u_out_skid (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .in_data  (result),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_data (rsp_data)
   );

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// ---------------------------------------------------------------------------
// length_field_frame_receiver testbench
// Drives byte and release requests through the valid/stall channel and
// checks every result against a frame tracker kept alongside the block or a
// typed table row. A short stimulus table covers the corner cases. Random
// frames follow under several start/end byte settings and idle/stall mixes.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;

   localparam int BUFFER_BYTES = lffr_pkg::BUFFER_BYTES_DEF;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_GOAL = 90;

   // one row of the directed stimulus table
   typedef struct packed {
      logic              operation;
      logic [7:0]        byte_in;
      logic              typed;
      lffr_pkg::rsp_type result;
   } stim_row_type;

   localparam stim_row_type DIRECTED [0:26] = '{
      '{lffr_pkg::OP_RELEASE, 8'hFF, 1'b1, '{lffr_pkg::STATUS_IGNORED, 8'h00, 8'd0, 1'b0}},
      '{lffr_pkg::OP_BYTE,    8'h00, 1'b1, '{lffr_pkg::STATUS_IGNORED, 8'h00, 8'd0, 1'b0}},
      '{lffr_pkg::OP_BYTE,    8'hFF, 1'b1, '{lffr_pkg::STATUS_IGNORED, 8'h00, 8'd0, 1'b0}},
      '{lffr_pkg::OP_BYTE,    8'h55, 1'b1, '{lffr_pkg::STATUS_STORED, 8'h55, 8'd0, 1'b0}},
      '{lffr_pkg::OP_BYTE,    8'h00, 1'b0, '0},
      '{lffr_pkg::OP_BYTE,    8'hFF, 1'b0, '0},
      '{lffr_pkg::OP_BYTE,    8'h80, 1'b0, '0},
      '{lffr_pkg::OP_BYTE,    8'h01, 1'b0, '0},
      '{lffr_pkg::OP_BYTE,    8'h7F, 1'b0, '0},
      '{lffr_pkg::OP_BYTE,    8'hAA, 1'b0, '0},
      '{lffr_pkg::OP_BYTE,    8'h00, 1'b0, '0},
      '{lffr_pkg::OP_BYTE,    8'h12, 1'b0, '0},
      '{lffr_pkg::OP_BYTE,    8'h34, 1'b0, '0},
      '{lffr_pkg::OP_BYTE,    8'hAA, 1'b1, '{lffr_pkg::STATUS_COMPLETE, 8'hAA, 8'd10, 1'b1}},
      '{lffr_pkg::OP_BYTE,    8'h55, 1'b1, '{lffr_pkg::STATUS_IGNORED, 8'h00, 8'd0, 1'b0}},
      '{lffr_pkg::OP_RELEASE, 8'h00, 1'b1, '{lffr_pkg::STATUS_IGNORED, 8'h00, 8'd0, 1'b0}},
      '{lffr_pkg::OP_BYTE,    8'h55, 1'b1, '{lffr_pkg::STATUS_STORED, 8'h55, 8'd0, 1'b0}},
      '{lffr_pkg::OP_BYTE,    8'h01, 1'b0, '0},
      '{lffr_pkg::OP_BYTE,    8'h02, 1'b0, '0},
      '{lffr_pkg::OP_BYTE,    8'h04, 1'b0, '0},
      '{lffr_pkg::OP_BYTE,    8'h08, 1'b0, '0},
      '{lffr_pkg::OP_BYTE,    8'h10, 1'b0, '0},
      '{lffr_pkg::OP_BYTE,    8'h20, 1'b0, '0},
      '{lffr_pkg::OP_BYTE,    8'h00, 1'b0, '0},
      '{lffr_pkg::OP_BYTE,    8'h55, 1'b0, '0},
      '{lffr_pkg::OP_BYTE,    8'h55, 1'b0, '0},
      '{lffr_pkg::OP_BYTE,    8'hAB, 1'b1, '{lffr_pkg::STATUS_DROPPED, 8'hAB, 8'd10, 1'b0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   lffr_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   lffr_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [lffr_pkg::CSR_INDEX_W-1:0] csr_index = lffr_pkg::CSR_START_BYTE;
   logic [7:0] csr_wdata = 8'h00;

   // frame tracker state and its copy of the registers
   lffr_pkg::phase_type rx_phase = lffr_pkg::PHASE_HUNT;
   logic [lffr_pkg::COUNT_W-1:0] rx_count = '0;
   logic [lffr_pkg::COUNT_W-1:0] rx_length = '0;
   logic [7:0] cfg_start = lffr_pkg::START_BYTE_RESET;
   logic [7:0] cfg_end = lffr_pkg::END_BYTE_RESET;

   // results still owed by the block, oldest first
   lffr_pkg::rsp_type frame_result_q[$];

   logic typed_known = 1'b0;
   lffr_pkg::rsp_type typed_rsp = '0;
   int req_taken = 0;
   int framed_count = 0;
   int mismatches = 0;
   int quiet_cycles = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   length_field_frame_receiver u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // advance the frame tracker by one request and return its result
   function automatic lffr_pkg::rsp_type track_frame(lffr_pkg::req_type r);
      lffr_pkg::rsp_type res;
      lffr_pkg::status_type st;
      logic [7:0] pos;
      logic took;
      res = '0;
      st = lffr_pkg::STATUS_STORED;
      pos = 8'd0;
      took = 1'b1;
      if (r.operation == lffr_pkg::OP_RELEASE) begin
         if (rx_phase == lffr_pkg::PHASE_HELD) rx_phase = lffr_pkg::PHASE_HUNT;
         return res;
      end
      case (rx_phase)
         lffr_pkg::PHASE_HUNT: begin
            if (r.byte_in == cfg_start) begin
               rx_phase = lffr_pkg::PHASE_HEADER;
               rx_count = 9'd1;
            end else begin
               took = 1'b0;
            end
         end
         lffr_pkg::PHASE_HEADER: begin
            pos = rx_count[7:0];
            rx_count = rx_count + 9'd1;
            if (rx_count == lffr_pkg::LENGTH_POSITION) begin
               rx_length = {1'b0, r.byte_in} + lffr_pkg::LENGTH_OFFSET;
               rx_phase = lffr_pkg::PHASE_DATA;
            end
            if (int'(rx_count) > BUFFER_BYTES) begin
               rx_phase = lffr_pkg::PHASE_HUNT;
               st = lffr_pkg::STATUS_DROPPED;
            end
         end
         lffr_pkg::PHASE_DATA: begin
            pos = rx_count[7:0];
            rx_count = rx_count + 9'd1;
            if (int'(rx_count) > BUFFER_BYTES) begin
               rx_phase = lffr_pkg::PHASE_HUNT;
               st = lffr_pkg::STATUS_DROPPED;
            end
            // end check wins over overflow on the same byte
            if (rx_count >= rx_length) begin
               if (r.byte_in == cfg_end) begin
                  rx_phase = lffr_pkg::PHASE_HELD;
                  st = lffr_pkg::STATUS_COMPLETE;
               end else begin
                  rx_phase = lffr_pkg::PHASE_HUNT;
                  st = lffr_pkg::STATUS_DROPPED;
               end
            end
         end
         default: took = 1'b0;
      endcase
      if (took) begin
         res.status = st;
         res.byte_out = r.byte_in;
         res.position = pos;
         res.frame_done = (st == lffr_pkg::STATUS_COMPLETE);
      end
      return res;
   endfunction

   // result stall, changed at the falling edge
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < rsp_stall_pct);
   end

   // sample both channels at the rising edge
   always @(posedge clock) begin : channel_monitor
      lffr_pkg::rsp_type want;
      logic moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (frame_result_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: status %0d byte %h pos %0d done %0b",
                           rsp_data.status, rsp_data.byte_out, rsp_data.position,
                           rsp_data.frame_done);
            end else begin
               want = frame_result_q.pop_front();
               if (rsp_data.status !== want.status || rsp_data.byte_out !== want.byte_out ||
                   rsp_data.position !== want.position ||
                   rsp_data.frame_done !== want.frame_done) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %0d/%h/%0d/%0b got %0d/%h/%0d/%0b",
                              want.status, want.byte_out, want.position, want.frame_done,
                              rsp_data.status, rsp_data.byte_out, rsp_data.position,
                              rsp_data.frame_done);
               end
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            want = track_frame(req_data);
            if (typed_known) want = typed_rsp;
            frame_result_q.push_back(want);
            if (want.status != lffr_pkg::STATUS_IGNORED) framed_count++;
            req_taken++;
         end
         // watchdog on cycles with no progress
         if (moved) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("Some tests failed");
               $finish;
            end
         end
      end
   end

   // offer one request and hold it until it is taken
   task automatic send_req(input logic op, input logic [7:0] b, input logic known,
                           input lffr_pkg::rsp_type exp);
      int taken_before;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data.operation = op;
      req_data.byte_in = b;
      typed_known = known;
      typed_rsp = exp;
      taken_before = req_taken;
      do @(negedge clock); while (req_taken == taken_before);
   endtask

   // stop sending and wait until every owed result has arrived
   task automatic drain();
      req_valid = 1'b0;
      while (frame_result_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [lffr_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [7:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == lffr_pkg::CSR_START_BYTE) cfg_start = val;
      else cfg_end = val;
   endtask

   // one random frame, sometimes cut short, then noise and usually a release
   task automatic send_random_frame();
      int pick;
      int len;
      int total;
      int cut;
      logic [7:0] len_byte;
      logic [7:0] b;
      pick = $urandom_range(99);
      if (pick < 76) len_byte = 8'($urandom_range(12, 0));
      else if (pick < 86) len_byte = 8'($urandom_range(119, 117));
      else if (pick < 90) len_byte = 8'($urandom_range(255, 120));
      else len_byte = 8'($urandom_range(60, 13));
      len = int'(len_byte) + 11;
      total = (len > BUFFER_BYTES + 1) ? BUFFER_BYTES + 1 : len;
      cut = ($urandom_range(99) < 12) ? int'($urandom_range(total - 1, 1)) : total;
      for (int p = 0; p < cut; p++) begin
         if (p == 0) b = cfg_start;
         else if (p == 7) b = len_byte;
         else if (p == total - 1 && $urandom_range(99) < 85) b = cfg_end;
         else b = 8'($urandom);
         send_req(lffr_pkg::OP_BYTE, b, 1'b0, '0);
      end
      repeat ($urandom_range(2)) send_req(1'($urandom_range(1)), 8'($urandom), 1'b0, '0);
      if ($urandom_range(99) < 85) send_req(lffr_pkg::OP_RELEASE, 8'($urandom), 1'b0, '0);
   endtask

   initial begin
      int goal;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // directed table under reset register values
      foreach (DIRECTED[i])
         send_req(DIRECTED[i].operation, DIRECTED[i].byte_in, DIRECTED[i].typed,
                  DIRECTED[i].result);

      // random frames under several register settings and idle mixes
      for (int m = 0; m < 4; m++) begin
         drain();
         case (m)
            0: begin
               write_csr(lffr_pkg::CSR_START_BYTE, 8'h00);
               write_csr(lffr_pkg::CSR_END_BYTE, 8'hFF);
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               write_csr(lffr_pkg::CSR_START_BYTE, 8'hFF);
               write_csr(lffr_pkg::CSR_END_BYTE, 8'h00);
               send_idle_pct = 83;
               rsp_stall_pct = 0;
            end
            2: begin
               write_csr(lffr_pkg::CSR_START_BYTE, 8'($urandom));
               write_csr(lffr_pkg::CSR_END_BYTE, 8'($urandom));
               send_idle_pct = 0;
               rsp_stall_pct = 83;
            end
            default: begin
               write_csr(lffr_pkg::CSR_START_BYTE, 8'h7E);
               write_csr(lffr_pkg::CSR_END_BYTE, 8'h7E);
               send_idle_pct = 32;
               rsp_stall_pct = 32;
            end
         endcase
         goal = framed_count + PHASE_GOAL;
         while (framed_count < goal) send_random_frame();
      end

      drain();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && frame_result_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
